[src/gsbc_pkg.sv]
// Package: shared constants, types and codes of the gyro startup bias calibration block.
`timescale 1ns / 1ps
package gsbc_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int FRAC_BITS    = 16;
  localparam int TIME_WIDTH   = 32;

  localparam int SW = SAMPLE_WIDTH;
  localparam int TW = TIME_WIDTH;

  // Filter coefficients, unsigned with COEF_BITS fraction bits.
  localparam int COEF_BITS = 16;
  localparam logic [COEF_BITS-1:0] COEF_FAST = COEF_BITS'(3277);
  localparam logic [COEF_BITS-1:0] COEF_SLOW = COEF_BITS'(328);

  // Register widths and reset values.
  localparam int THR_W    = 31;
  localparam int MS_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [THR_W-1:0] RESET_THRESHOLD = THR_W'(655);
  localparam logic [MS_W-1:0]  RESET_SETTLE    = MS_W'(4100);
  localparam logic [MS_W-1:0]  RESET_TIMEOUT   = MS_W'(15000);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  // Queue depth between stages (power of two).
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef logic signed [SW-1:0] sample_t;
  typedef sample_t [2:0] vec3_t;
  typedef logic [TW-1:0] stamp_t;

  typedef enum logic [1:0] {
    ST_CAL     = 2'd0,
    ST_STILL   = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CAL  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [MS_W-1:0]  settle;
    logic [MS_W-1:0]  timeout;
  } cfg_t;

  typedef struct packed {
    vec3_t  gyro;
    stamp_t ts;
    logic   first;
  } in_item_t;

  typedef struct packed {
    vec3_t  gyro;
    stamp_t ts;
    logic   first;
    vec3_t  fast;
    vec3_t  slow;
  } filt_item_t;

  typedef struct packed {
    vec3_t   gyro;
    vec3_t   bias;
    status_t status;
  } out_item_t;

endpackage

[src/gsbc_front.sv]
// Front end: input queue that takes sample beats and marks the first one after reset.
`timescale 1ns / 1ps
module gsbc_front import gsbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t item_in,
  output logic     fq_valid,
  output in_item_t fq_item,
  input  logic     fq_pop
);

  in_item_t         mem_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   cnt_r;
  logic             seen_r;
  logic             do_push, do_pop;
  in_item_t         marked;

  assign full     = (cnt_r == QCW'(QDEPTH));
  assign fq_valid = (cnt_r != '0);
  assign fq_item  = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = fq_pop && fq_valid;

  always_comb begin
    marked       = item_in;
    marked.first = !seen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      seen_r   <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
        seen_r   <= 1'b1;
      end
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + QCW'(do_push) - QCW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= marked;
  end

endmodule

[src/gsbc_filter.sv]
// Filter stage: fast and slow EMAs on all three axes, one sample a cycle unless stalled.
`timescale 1ns / 1ps
module gsbc_filter import gsbc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fq_valid,
  input  in_item_t   fq_item,
  output logic       fq_pop,
  output logic       s1_valid,
  output filt_item_t s1_item,
  input  logic       s1_pop
);

  localparam int DW = SW + 1;
  localparam int PW = DW + COEF_BITS + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (COEF_BITS - 1);

  logic       v_r;
  vec3_t      gyro_r, fast_r, slow_r;
  stamp_t     ts_r;
  logic       first_r;
  vec3_t      fast_nxt, slow_nxt;

  // One filter step: old + round_half_up((x - old) * coef / 2^COEF_BITS).
  function automatic sample_t step(sample_t x, sample_t old, logic [COEF_BITS-1:0] coef);
    logic signed [DW-1:0] d;
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
    d = $signed({x[SW-1], x}) - $signed({old[SW-1], old});
    p = d * $signed({1'b0, coef});
    q = (p + HALF) >>> COEF_BITS;
    return sample_t'(old + q[SW-1:0]);
  endfunction

  assign fq_pop   = fq_valid && (!v_r || s1_pop);
  assign s1_valid = v_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // The first sample seeds both filters before its own step.
      fast_nxt[i] = step(fq_item.gyro[i], fq_item.first ? fq_item.gyro[i] : fast_r[i],
                         COEF_FAST);
      slow_nxt[i] = step(fq_item.gyro[i], fq_item.first ? fq_item.gyro[i] : slow_r[i],
                         COEF_SLOW);
    end
  end

  always_comb begin
    s1_item.gyro  = gyro_r;
    s1_item.ts    = ts_r;
    s1_item.first = first_r;
    s1_item.fast  = fast_r;
    s1_item.slow  = slow_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (fq_pop) begin
      v_r <= 1'b1;
    end else if (s1_pop) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fq_pop) begin
      gyro_r  <= fq_item.gyro;
      ts_r    <= fq_item.ts;
      first_r <= fq_item.first;
      fast_r  <= fast_nxt;
      slow_r  <= slow_nxt;
    end
  end

endmodule

[src/gsbc_decide.sv]
// Decision stage: motion check, settle and timeout timers, bias freeze and bias removal.
`timescale 1ns / 1ps
module gsbc_decide import gsbc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       s1_valid,
  input  filt_item_t s1_item,
  output logic       s1_pop,
  input  logic       oq_full,
  output logic       oq_push,
  output out_item_t  oq_item
);

  localparam int DW = SW + 1;
  localparam int GW = (DW > THR_W) ? DW : THR_W;
  localparam sample_t SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t SMIN = {1'b1, {(SW-1){1'b0}}};

  phase_t  phase_r, phase_nxt;
  vec3_t   bias_r, bias_nxt;
  stamp_t  still_start_r, still_start_nxt;
  stamp_t  phase_start_r, phase_start_nxt;
  logic    timeout_r, timeout_nxt;

  logic    restart, timed, settled, done;
  stamp_t  ss_eff, ps_eff, still_for, running_for;
  logic signed [DW-1:0] gap_d, sub_d;
  logic [DW-1:0] gap_mag;

  assign s1_pop  = s1_valid && !oq_full;
  assign oq_push = s1_pop;

  always_comb begin
    restart = 1'b0;
    for (int i = 0; i < 3; i++) begin
      gap_d   = $signed({s1_item.slow[i][SW-1], s1_item.slow[i]})
              - $signed({s1_item.fast[i][SW-1], s1_item.fast[i]});
      gap_mag = gap_d[DW-1] ? DW'(-gap_d) : DW'(gap_d);
      if (GW'(gap_mag) > GW'(cfg.threshold)) restart = 1'b1;
    end

    ss_eff      = s1_item.first ? s1_item.ts : still_start_r;
    ps_eff      = s1_item.first ? s1_item.ts : phase_start_r;
    still_for   = restart ? '0 : stamp_t'(s1_item.ts - ss_eff);
    running_for = stamp_t'(s1_item.ts - ps_eff);
    timed       = running_for > TW'(cfg.timeout);
    settled     = still_for > TW'(cfg.settle);
    done        = timed || settled;

    phase_nxt       = phase_r;
    bias_nxt        = bias_r;
    still_start_nxt = still_start_r;
    phase_start_nxt = phase_start_r;
    timeout_nxt     = timeout_r;
    sub_d           = '0;
    oq_item.gyro    = s1_item.gyro;
    oq_item.bias    = bias_r;
    oq_item.status  = timeout_r ? ST_TIMEOUT : ST_STILL;

    case (phase_r)
      PH_IDLE, PH_CAL: begin
        bias_nxt        = s1_item.slow;
        still_start_nxt = restart ? s1_item.ts : ss_eff;
        phase_start_nxt = ps_eff;
        oq_item.bias    = s1_item.slow;
        if (done) begin
          phase_nxt      = PH_DONE;
          timeout_nxt    = timed;
          oq_item.status = timed ? ST_TIMEOUT : ST_STILL;
        end else begin
          phase_nxt      = PH_CAL;
          oq_item.status = ST_CAL;
        end
      end
      default: begin
        // Remove the frozen bias, saturate on overflow.
        for (int i = 0; i < 3; i++) begin
          sub_d = $signed({s1_item.gyro[i][SW-1], s1_item.gyro[i]})
                - $signed({bias_r[i][SW-1], bias_r[i]});
          if (sub_d[DW-1] != sub_d[DW-2]) oq_item.gyro[i] = sub_d[DW-1] ? SMIN : SMAX;
          else oq_item.gyro[i] = sub_d[SW-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bias_r    <= '0;
      timeout_r <= 1'b0;
    end else if (s1_pop) begin
      phase_r   <= phase_nxt;
      bias_r    <= bias_nxt;
      timeout_r <= timeout_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_pop) begin
      still_start_r <= still_start_nxt;
      phase_start_r <= phase_start_nxt;
    end
  end

endmodule

[src/gsbc_out_queue.sv]
// Result queue: holds finished result beats until they are popped.
`timescale 1ns / 1ps
module gsbc_out_queue import gsbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t item_in,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output out_item_t head
);

  out_item_t      mem_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == QCW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + QCW'(do_push) - QCW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= item_in;
  end

endmodule

[src/gyro_startup_bias_calibration_unit.sv]
// Top level: gyro startup bias calibration with input queue, filter, decision and result queue.
`timescale 1ns / 1ps
// The unit accepts one gyro sample beat per clock while in_full is low and returns
// one result beat per sample, in order. When the result side does not stall, the
// input beat is written into the input queue at the accepting edge, then into the
// filter register, then into the result queue, whose head drives the out ports. The
// fast and slow filters close their feedback combinationally, a constant multiply
// and add per axis, and that loop sets the rate of one sample per clock when nothing
// stalls. From the first sample after reset the unit calibrates: out_gyro_*
// carries the raw rate and out_bias_* the slow filter value, out_cal_status is zero. When
// the filters have agreed within motion_threshold for more than settle_ms, or more than
// timeout_ms have passed since the first sample, the slow value is frozen as bias and
// out_cal_status turns to one (still) or two (timeout); every later sample leaves with the
// bias subtracted and saturated. Both queues hold two beats, so a full result queue stops
// the filter stage while the input side still takes beats. Write configuration registers
// (0 threshold, 1 settle time, 2 timeout) only while the unit is idle; writes to index 3
// are dropped. No clearing pass follows reset: the unit is ready at once.
module gyro_startup_bias_calibration_unit import gsbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic signed [SW-1:0]  in_gyro_x,
  input  logic signed [SW-1:0]  in_gyro_y,
  input  logic signed [SW-1:0]  in_gyro_z,
  input  logic [TW-1:0]         in_timestamp_ms,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic signed [SW-1:0]  out_gyro_x,
  output logic signed [SW-1:0]  out_gyro_y,
  output logic signed [SW-1:0]  out_gyro_z,
  output logic signed [SW-1:0]  out_bias_x,
  output logic signed [SW-1:0]  out_bias_y,
  output logic signed [SW-1:0]  out_bias_z,
  output logic [1:0]            out_cal_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg_r;
  in_item_t   in_item;
  logic       fq_valid, fq_pop;
  in_item_t   fq_item;
  logic       s1_valid, s1_pop;
  filt_item_t s1_item;
  logic       oq_full, oq_push;
  out_item_t  oq_item, oq_head;

  // Configuration: always ready, mask data to the register width.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= RESET_THRESHOLD;
      cfg_r.settle    <= RESET_SETTLE;
      cfg_r.timeout   <= RESET_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD: cfg_r.threshold <= cfg_data[THR_W-1:0];
        CFG_SETTLE:    cfg_r.settle    <= cfg_data[MS_W-1:0];
        CFG_TIMEOUT:   cfg_r.timeout   <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.gyro[0] = in_gyro_x;
    in_item.gyro[1] = in_gyro_y;
    in_item.gyro[2] = in_gyro_z;
    in_item.ts      = in_timestamp_ms;
    in_item.first   = 1'b0;  // set by the front end
  end

  gsbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .full     (in_full),
    .item_in  (in_item),
    .fq_valid (fq_valid),
    .fq_item  (fq_item),
    .fq_pop   (fq_pop)
  );

  gsbc_filter u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .fq_valid (fq_valid),
    .fq_item  (fq_item),
    .fq_pop   (fq_pop),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_pop   (s1_pop)
  );

  // The filter stage keeps filtering after the bias is frozen; the decision stage
  // ignores those values once its phase is done.
  gsbc_decide u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_pop   (s1_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_item  (oq_item)
  );

  gsbc_out_queue u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (oq_push),
    .item_in (oq_item),
    .full    (oq_full),
    .pop     (out_pop),
    .empty   (out_empty),
    .head    (oq_head)
  );

  assign out_gyro_x     = oq_head.gyro[0];
  assign out_gyro_y     = oq_head.gyro[1];
  assign out_gyro_z     = oq_head.gyro[2];
  assign out_bias_x     = oq_head.bias[0];
  assign out_bias_y     = oq_head.bias[1];
  assign out_bias_z     = oq_head.bias[2];
  assign out_cal_status = oq_head.status;

endmodule

[src/gsbc_checker.sv]
// Port checker for the calibration unit and its bind to the top level.
`timescale 1ns / 1ps
module gsbc_checker import gsbc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_empty,
  input logic                 out_pop,
  input logic signed [SW-1:0] out_gyro_x,
  input logic signed [SW-1:0] out_bias_x,
  input logic signed [SW-1:0] out_bias_y,
  input logic signed [SW-1:0] out_bias_z,
  input logic [1:0]           out_cal_status
);

  logic                 done_seen_r;
  logic [1:0]           status_r;
  logic signed [SW-1:0] bx_r, by_r, bz_r;

  // Remember the frozen bias and status from the first finished result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_seen_r <= 1'b0;
      status_r    <= '0;
      bx_r        <= '0;
      by_r        <= '0;
      bz_r        <= '0;
    end else if (out_pop && !out_empty && !done_seen_r &&
                 out_cal_status != ST_CAL) begin
      done_seen_r <= 1'b1;
      status_r    <= out_cal_status;
      bx_r        <= out_bias_x;
      by_r        <= out_bias_y;
      bz_r        <= out_bias_z;
    end
  end

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_gyro_x)))
    else $error("waiting result beat changed before pop");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_cal_status == ST_CAL || out_cal_status == ST_STILL ||
                    out_cal_status == ST_TIMEOUT))
    else $error("undefined calibration status");

  a_status_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && done_seen_r) |-> out_cal_status == status_r)
    else $error("status changed after calibration finished");

  a_bias_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && done_seen_r) |->
      (out_bias_x == bx_r && out_bias_y == by_r && out_bias_z == bz_r))
    else $error("bias changed after calibration finished");

endmodule

bind gyro_startup_bias_calibration_unit gsbc_checker u_gsbc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_gyro_x     (out_gyro_x),
  .out_bias_x     (out_bias_x),
  .out_bias_y     (out_bias_y),
  .out_bias_z     (out_bias_z),
  .out_cal_status (out_cal_status)
);

[test/tb_gyro_startup_bias_calibration_unit.sv]
// Testbench: drives gyro sample beats through the calibration unit and checks every result beat.
`timescale 1ns / 1ps
module tb_gyro_startup_bias_calibration_unit;
  import gsbc_pkg::*;

  // Watchdog, in clock cycles.
  localparam int unsigned LIMIT_CYCLES = 400000;

  // Filter gains, unsigned with 16 fraction bits (0.05 and 0.005 rounded to nearest).
  localparam longint FAST_GAIN = 3277;
  localparam longint SLOW_GAIN = 328;
  localparam int     GAIN_FRAC = 16;

  // Register values right after reset.
  localparam logic [THR_W-1:0] BOOT_THRESHOLD = 31'd655;
  localparam logic [MS_W-1:0]  BOOT_SETTLE    = 16'd4100;
  localparam logic [MS_W-1:0]  BOOT_TIMEOUT   = 16'd15000;

  // The one index the register file does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam sample_t RATE_TOP    = 32'sh7FFF_FFFF;
  localparam sample_t RATE_BOTTOM = 32'sh8000_0000;

  typedef struct packed {
    sample_t gx;
    sample_t gy;
    sample_t gz;
    sample_t bx;
    sample_t by;
    sample_t bz;
    status_t st;
  } rate_rec_t;

  typedef struct packed {
    sample_t   gx;
    sample_t   gy;
    sample_t   gz;
    stamp_t    ts;
    logic      typed;
    rate_rec_t want;
  } lead_row_t;

  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_COIN,
    POP_THIRD,
    POP_BURSTY
  } pop_mode_t;

  typedef enum logic [1:0] {
    END_STILL,
    END_TIMEOUT,
    END_BOTH
  } end_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_push = 1'b0;
  logic                  in_full;
  sample_t               in_gyro_x = '0;
  sample_t               in_gyro_y = '0;
  sample_t               in_gyro_z = '0;
  stamp_t                in_timestamp_ms = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  sample_t               out_gyro_x;
  sample_t               out_gyro_y;
  sample_t               out_gyro_z;
  sample_t               out_bias_x;
  sample_t               out_bias_y;
  sample_t               out_bias_z;
  logic [1:0]            out_cal_status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  gyro_startup_bias_calibration_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_gyro_x       (in_gyro_x),
    .in_gyro_y       (in_gyro_y),
    .in_gyro_z       (in_gyro_z),
    .in_timestamp_ms (in_timestamp_ms),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_gyro_x      (out_gyro_x),
    .out_gyro_y      (out_gyro_y),
    .out_gyro_z      (out_gyro_z),
    .out_bias_x      (out_bias_x),
    .out_bias_y      (out_bias_y),
    .out_bias_z      (out_bias_z),
    .out_cal_status  (out_cal_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // ---------------------------------------------------------------------------------------
  // Calibration predictor: own copy of the registers, both filters, timers and frozen bias.
  // Filters are kept as 64-bit values so the difference and product never wrap.
  // ---------------------------------------------------------------------------------------
  logic [THR_W-1:0] thr_q    = BOOT_THRESHOLD;
  logic [MS_W-1:0]  settle_q = BOOT_SETTLE;
  logic [MS_W-1:0]  tmo_q    = BOOT_TIMEOUT;

  phase_t cal_phase = PH_IDLE;
  longint fast_f [3];
  longint slow_f [3];
  longint bias_f [3] = '{0, 0, 0};
  stamp_t still_since;
  stamp_t cal_since;
  logic   ended_late = 1'b0;

  rate_rec_t pending_rates [$];
  int        fail_count = 0;

  // Random content: a per-run rest rate per axis plus noise around it.
  longint      center_rate [3];
  int unsigned noise_amp = 1;
  stamp_t      now_ms = '0;

  // Round half up of diff * gain / 2^16; the arithmetic shift floors.
  function automatic longint filter_nudge(input longint diff, input longint gain);
    return (diff * gain + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
  endfunction

  function automatic sample_t clamp_rate(input longint v);
    if (v > longint'(RATE_TOP)) return RATE_TOP;
    if (v < longint'(RATE_BOTTOM)) return RATE_BOTTOM;
    return sample_t'(v);
  endfunction

  // Register write as the unit sees it: index 3 drops, upper data bits are masked off.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_THRESHOLD: thr_q = data[THR_W-1:0];
      CFG_SETTLE:    settle_q = data[MS_W-1:0];
      CFG_TIMEOUT:   tmo_q = data[MS_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the calibration by one sample and return the result beat it must cause.
  function automatic rate_rec_t calib_step(input sample_t gx, gy, gz, input stamp_t ts);
    sample_t   g [3];
    longint    gap;
    longint    d;
    stamp_t    still_for;
    stamp_t    run_for;
    logic      late;
    rate_rec_t r;
    g[0] = gx;
    g[1] = gy;
    g[2] = gz;
    if (cal_phase != PH_DONE) begin
      // First sample seeds both filters and both timers, then filters as usual.
      if (cal_phase == PH_IDLE) begin
        for (int i = 0; i < 3; i++) begin
          fast_f[i] = longint'(g[i]);
          slow_f[i] = longint'(g[i]);
        end
        cal_since = ts;
        still_since = ts;
        cal_phase = PH_CAL;
      end
      gap = 0;
      for (int i = 0; i < 3; i++) begin
        fast_f[i] = fast_f[i] + filter_nudge(longint'(g[i]) - fast_f[i], FAST_GAIN);
        slow_f[i] = slow_f[i] + filter_nudge(longint'(g[i]) - slow_f[i], SLOW_GAIN);
        bias_f[i] = slow_f[i];
        d = slow_f[i] - fast_f[i];
        if (d < 0) d = -d;
        if (d > gap) gap = d;
      end
      if (gap > longint'(thr_q)) still_since = ts;
      still_for = ts - still_since;
      run_for = ts - cal_since;
      late = run_for > tmo_q;
      if (still_for > settle_q || late) begin
        cal_phase = PH_DONE;
        ended_late = late;
      end
      r.gx = gx;
      r.gy = gy;
      r.gz = gz;
    end else begin
      r.gx = clamp_rate(longint'(gx) - bias_f[0]);
      r.gy = clamp_rate(longint'(gy) - bias_f[1]);
      r.gz = clamp_rate(longint'(gz) - bias_f[2]);
    end
    r.bx = sample_t'(bias_f[0]);
    r.by = sample_t'(bias_f[1]);
    r.bz = sample_t'(bias_f[2]);
    if (cal_phase != PH_DONE) r.st = ST_CAL;
    else r.st = ended_late ? ST_TIMEOUT : ST_STILL;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Directed lead-in, run with the reset register values. Timestamps start just below the
  // 32-bit wrap so the timers see a rollover. The first beat seeds both filters, so its
  // result is the sample itself with bias equal to it; a repeat of the same sample leaves
  // the filters alone and must read back the same. Every other row goes through the
  // predictor: full-scale swings on all axes, zero, +-1, alternating bit patterns and a
  // repeated timestamp.
  // ---------------------------------------------------------------------------------------
  lead_row_t lead_rows [0:11] = '{
    '{RATE_TOP, RATE_BOTTOM, 32'sh0, 32'hFFFF_FF00, 1'b1,
      '{RATE_TOP, RATE_BOTTOM, 32'sh0, RATE_TOP, RATE_BOTTOM, 32'sh0, ST_CAL}},
    '{RATE_TOP, RATE_BOTTOM, 32'sh0, 32'hFFFF_FF10, 1'b1,
      '{RATE_TOP, RATE_BOTTOM, 32'sh0, RATE_TOP, RATE_BOTTOM, 32'sh0, ST_CAL}},
    '{RATE_BOTTOM, RATE_TOP, -32'sh1, 32'hFFFF_FF20, 1'b0, '0},
    '{32'sh0, 32'sh0, 32'sh0, 32'hFFFF_FFFF, 1'b0, '0},
    '{32'sh1, -32'sh1, 32'sh0001_0000, 32'h0000_0000, 1'b0, '0},
    '{RATE_TOP, RATE_TOP, RATE_TOP, 32'h0000_0010, 1'b0, '0},
    '{RATE_BOTTOM, RATE_BOTTOM, RATE_BOTTOM, 32'h0000_0020, 1'b0, '0},
    '{32'sh0000_8000, -32'sh0000_8000, 32'sh1, 32'h0000_0100, 1'b0, '0},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333, 32'h0000_1000, 1'b0, '0},
    '{32'shAAAA_AAAA, 32'sh5555_5555, 32'shCCCC_CCCC, 32'h0000_1000, 1'b0, '0},
    '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'h0000_2000, 1'b0, '0},
    '{32'sh0, 32'sh0, 32'sh0, 32'h0000_2000, 1'b0, '0}
  };

  // Pick one axis rate: rest rate plus noise, any 32-bit value, or a corner value.
  function automatic sample_t draw_rate(input int axis, input int still_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < still_pct)
      return sample_t'(center_rate[axis] + longint'($urandom_range(0, 2 * noise_amp))
                       - longint'(noise_amp));
    if (r < still_pct + (100 - still_pct) / 2) return sample_t'($urandom);
    case ($urandom_range(0, 4))
      0: return RATE_TOP;
      1: return RATE_BOTTOM;
      2: return 32'sh0;
      3: return -32'sh1;
      default: return 32'sh1;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Sender side. Every task starts right after a rising edge. Push stays high from one beat
  // to the next inside a burst and drops only in a gap, so it is never lowered and raised
  // in the same step.
  // ---------------------------------------------------------------------------------------
  task automatic push_sample(input sample_t gx, gy, gz, input stamp_t ts,
                             input logic typed, input rate_rec_t typed_rec);
    rate_rec_t want;
    in_push <= 1'b1;
    in_gyro_x <= gx;
    in_gyro_y <= gy;
    in_gyro_z <= gz;
    in_timestamp_ms <= ts;
    // Hold the beat until the unit takes it.
    do @(posedge clk); while (in_full);
    want = calib_step(gx, gy, gz, ts);
    if (typed) want = typed_rec;
    pending_rates.push_back(want);
  endtask

  task automatic idle_for(input int cycles);
    in_push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending until every result beat is back; the unit is idle afterwards.
  task automatic drain_results();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_rates.size() != 0);
  endtask

  // Write all registers, index 3 first with junk that must be dropped.
  task automatic program_regs(input logic [31:0] thr_raw, settle_raw, tmo_raw);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [31:0]          val [4];
    idx = '{CFG_UNUSED, CFG_THRESHOLD, CFG_SETTLE, CFG_TIMEOUT};
    val = '{$urandom, thr_raw, settle_raw, tmo_raw};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      do @(posedge clk); while (!cfg_ready);
      apply_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random sample beats in bursts of random length with random gaps between them.
  // Timestamps either creep forward by up to max_step ms or, once the bias is frozen and
  // they no longer matter, are drawn over the full 32 bits.
  task automatic run_items(input int count, input int still_pct, input int max_step,
                           input logic free_stamps, input logic until_done);
    int      burst_left;
    int      gap;
    sample_t gx;
    sample_t gy;
    sample_t gz;
    burst_left = $urandom_range(1, 12);
    noise_amp = 1 << $urandom_range(0, 12);
    for (int n = 0; n < count; n++) begin
      if (until_done && cal_phase == PH_DONE) break;
      gx = draw_rate(0, still_pct);
      gy = draw_rate(1, still_pct);
      gz = draw_rate(2, still_pct);
      if (free_stamps) now_ms = $urandom;
      else now_ms = now_ms + $urandom_range(until_done ? 1 : 0, max_step);
      push_sample(gx, gy, gz, now_ms, 1'b0, '0);
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        if (gap > 0) idle_for(gap);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side: check the beat on the ports against the oldest prediction, then pick the
  // next pop value. The stall pattern is redrawn at random during the run.
  // ---------------------------------------------------------------------------------------
  function automatic void check_field(input string what, input sample_t want, input sample_t got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  pop_mode_t   pop_mode = POP_ALWAYS;
  int unsigned pop_tick = 0;

  always @(posedge clk) begin : result_side
    rate_rec_t want;
    if (out_pop && !out_empty) begin
      if (pending_rates.size() == 0) begin
        $display("%0t: result beat expected none actual out_gyro_x %0d",
                 $time, out_gyro_x);
        fail_count++;
      end else begin
        want = pending_rates.pop_front();
        check_field("out_gyro_x", want.gx, out_gyro_x);
        check_field("out_gyro_y", want.gy, out_gyro_y);
        check_field("out_gyro_z", want.gz, out_gyro_z);
        check_field("out_bias_x", want.bx, out_bias_x);
        check_field("out_bias_y", want.by, out_bias_y);
        check_field("out_bias_z", want.bz, out_bias_z);
        check_field("out_cal_status", sample_t'(want.st), sample_t'(out_cal_status));
      end
    end
    pop_tick++;
    if (pop_tick % 64 == 0) pop_mode = pop_mode_t'($urandom_range(0, 3));
    case (pop_mode)
      POP_ALWAYS: out_pop <= 1'b1;
      POP_COIN:   out_pop <= 1'($urandom_range(0, 1));
      POP_THIRD:  out_pop <= (pop_tick % 3 == 0);
      default:    out_pop <= pop_tick[3];
    endcase
  end

  // Watchdog: end the run if the stimulus never completes.
  int unsigned wd_cycles = 0;

  initial begin : watchdog
    while (wd_cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      wd_cycles++;
    end
    $display("gyro_startup_bias_calibration_unit regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Test sequence. Calibration runs once per reset, so the run keeps it alive across
  // several register settings (each written while idle), then ends it and checks the bias
  // subtraction for the rest of the run:
  //   lead-in  reset registers, directed rows across the timestamp wrap
  //   phase 1  threshold at full scale, settle and timeout at full scale
  //   phase 2  threshold zero, settle zero (constant motion keeps the timer restarting)
  //   phase 3  small threshold, mostly rest samples so the gap hovers around it
  //   ending   one of: stillness only, timeout only (sometimes zero), both on one sample
  //   frozen   random registers, full-range samples and timestamps, saturation corners
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    end_mode_t finish_by;
    for (int i = 0; i < 3; i++)
      center_rate[i] = longint'($signed($urandom)) >>> $urandom_range(1, 16);
    finish_by = end_mode_t'($urandom_range(0, 2));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (lead_rows[r]) begin
      push_sample(lead_rows[r].gx, lead_rows[r].gy, lead_rows[r].gz, lead_rows[r].ts,
                  lead_rows[r].typed, lead_rows[r].want);
      now_ms = lead_rows[r].ts;
      if (r % 4 == 3) idle_for($urandom_range(1, 5));
    end
    drain_results();

    // Upper data bits set on purpose: the unit must mask them away.
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hABCD_FFFF);
    run_items(300, 40, 25, 1'b0, 1'b0);
    drain_results();

    program_regs(32'h0, 32'hFFFF_0000, 32'h0000_FFFF);
    run_items(250, 30, 25, 1'b0, 1'b0);
    drain_results();

    program_regs($urandom_range(0, 6000), 32'h0001_FFFF, 32'h0000_FFFF);
    run_items(300, 85, 25, 1'b0, 1'b0);
    drain_results();

    // Close the calibration; keep sending until the predictor sees it done.
    case (finish_by)
      END_STILL: begin
        program_regs($urandom, $urandom_range(0, 3000), 32'h0000_FFFF);
        run_items(2000, 100, 200, 1'b0, 1'b1);
      end
      END_TIMEOUT: begin
        program_regs(32'h0, 32'h0000_FFFF,
                     ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom_range(0, 65535));
        run_items(2000, 50, 200, 1'b0, 1'b1);
      end
      default: begin
        program_regs(32'h7FFF_FFFF, 32'h0, 32'h0);
        run_items(2000, 100, 200, 1'b0, 1'b1);
      end
    endcase
    drain_results();

    program_regs($urandom, $urandom, $urandom);
    run_items(450, 50, 0, 1'b1, 1'b0);
    drain_results();

    // Let any stray beat show up before the verdict.
    repeat (16) @(posedge clk);
    if (fail_count == 0)
      $display("gyro_startup_bias_calibration_unit regression: pass");
    else
      $display("gyro_startup_bias_calibration_unit regression: fail");
    $finish;
  end

endmodule

[sim.f]
src/gsbc_pkg.sv
src/gsbc_front.sv
src/gsbc_filter.sv
src/gsbc_decide.sv
src/gsbc_out_queue.sv
src/gyro_startup_bias_calibration_unit.sv
src/gsbc_checker.sv
test/tb_gyro_startup_bias_calibration_unit.sv
